>>> sv/spq_pkg.sv
// spq_pkg: sizes, entry and control types shared by the sorted priority queue.
// No dependencies; used by the channel interfaces, the cell and the top level.
package spq_pkg;

  localparam int DEPTH         = 16;
  localparam int PRIORITY_BITS = 16;
  localparam int PAYLOAD_BITS  = 32;
  localparam int COUNT_BITS    = $clog2(DEPTH + 1);

  typedef enum logic [0:0] {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_t;

  typedef struct packed {
    logic [PRIORITY_BITS-1:0] pri;
    logic [PAYLOAD_BITS-1:0]  pay;
  } entry_t;

  // shift controls broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

>>> sv/spq_if.sv
// spq_if: valid/ready channel interfaces for the operation and result streams.
// Depends on spq_pkg for field widths and the operation code.
interface spq_in_if;
  logic                                 valid;
  logic                                 ready;
  spq_pkg::kind_t                       kind;
  logic [spq_pkg::PRIORITY_BITS-1:0]    new_priority;
  logic [spq_pkg::PAYLOAD_BITS-1:0]     new_payload;

  modport source (output valid, kind, new_priority, new_payload, input ready);
  modport sink   (input valid, kind, new_priority, new_payload, output ready);
endinterface

interface spq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [spq_pkg::PRIORITY_BITS-1:0]    top_priority;
  logic [spq_pkg::PAYLOAD_BITS-1:0]     top_payload;
  logic                                 top_valid;
  logic [spq_pkg::COUNT_BITS-1:0]       entry_count;
  logic                                 push_dropped;

  modport source (output valid, top_priority, top_payload, top_valid, entry_count,
                  push_dropped, input ready);
  modport sink   (input valid, top_priority, top_payload, top_valid, entry_count,
                  push_dropped, output ready);
endinterface

>>> sv/spq_cell.sv
// spq_cell: one slot of the sorted chain, holding a priority and payload.
// Depends on spq_pkg; instantiated DEPTH times by sorted_priority_queue.
module spq_cell (
  input  logic                clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::entry_t     new_entry,
  input  spq_pkg::entry_t     left_entry,
  input  logic                left_stay,
  input  spq_pkg::entry_t     right_entry,
  input  logic                occupied,
  output spq_pkg::entry_t     entry,
  output logic                stay,
  output spq_pkg::entry_t     entry_next
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // chain is kept in descending order: an entry strictly above the new one keeps its place
  assign stay = occupied && (entry_r.pri > new_entry.pri);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.push && !stay) begin
      entry_nxt = left_stay ? new_entry : left_entry;
    end else if (ctrl.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry      = entry_r;
  assign entry_next = entry_nxt;

endmodule

>>> sv/sorted_priority_queue.sv
// sorted_priority_queue: top level, a chain of spq_cell slots plus fill count and result register.
// Depends on spq_pkg, spq_in_if / spq_out_if and spq_cell.
//
// Sorted priority queue of up to spq_pkg::DEPTH entries. Every operation (push or pop) is one
// transfer on in_ch and produces exactly one result transfer on out_ch, offered in the next cycle, carrying
// the top entry, its valid flag, the entry count after the operation and a flag for a push that
// found the queue full. The queue takes one operation per clock: all cells compare against the
// new priority in parallel and shift toward or away from the head in the same cycle, so the only
// limit on rate is the single result register, and in_ch.ready falls only while a result waits
// that out_ch has not taken. Among equal priorities the entry pushed last is popped first.
// Slots beyond the fill count are never read and hold no reset value.
module sorted_priority_queue (
  input  logic             clk,
  input  logic             rst_n,
  spq_in_if.sink           in_ch,
  spq_out_if.source        out_ch
);

  localparam int CB = spq_pkg::COUNT_BITS;

  logic [CB-1:0]       count_r;
  logic [CB-1:0]       count_nxt;
  logic                out_valid_r;
  logic                accept;
  logic                is_push;
  logic                full;
  logic                empty;
  logic                dropped;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     new_entry;

  spq_pkg::entry_t     cell_entry [spq_pkg::DEPTH];
  spq_pkg::entry_t     cell_next  [spq_pkg::DEPTH];
  logic                cell_stay  [spq_pkg::DEPTH];
  logic                cell_occ   [spq_pkg::DEPTH];

  logic [spq_pkg::PRIORITY_BITS-1:0] top_priority_r;
  logic [spq_pkg::PAYLOAD_BITS-1:0]  top_payload_r;
  logic                              top_valid_r;
  logic [CB-1:0]                     entry_count_r;
  logic                              push_dropped_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_push     = (in_ch.kind == spq_pkg::KIND_PUSH);
  assign full        = (count_r == CB'(spq_pkg::DEPTH));
  assign empty       = (count_r == '0);
  assign dropped     = is_push && full;

  assign ctrl.push = accept && is_push && !full;
  assign ctrl.pop  = accept && !is_push && !empty;

  assign new_entry.pri = in_ch.new_priority;
  assign new_entry.pay = in_ch.new_payload;

  always_comb begin
    count_nxt = count_r;
    if (ctrl.push) begin
      count_nxt = count_r + CB'(1);
    end else if (ctrl.pop) begin
      count_nxt = count_r - CB'(1);
    end
  end

  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;
    logic            left_stay;

    assign cell_occ[i] = (count_r > CB'(i));

    if (i == 0) begin : g_head
      assign left_entry = new_entry;
      assign left_stay  = 1'b1;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_stay  = cell_stay[i-1];
    end

    if (i == spq_pkg::DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .new_entry   (new_entry),
      .left_entry  (left_entry),
      .left_stay   (left_stay),
      .right_entry (right_entry),
      .occupied    (cell_occ[i]),
      .entry       (cell_entry[i]),
      .stay        (cell_stay[i]),
      .entry_next  (cell_next[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register: head of the chain after this operation
  always_ff @(posedge clk) begin
    if (accept) begin
      top_valid_r    <= (count_nxt != '0);
      top_priority_r <= (count_nxt != '0) ? cell_next[0].pri : '0;
      top_payload_r  <= (count_nxt != '0) ? cell_next[0].pay : '0;
      entry_count_r  <= count_nxt;
      push_dropped_r <= dropped;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.top_priority = top_priority_r;
  assign out_ch.top_payload  = top_payload_r;
  assign out_ch.top_valid    = top_valid_r;
  assign out_ch.entry_count  = entry_count_r;
  assign out_ch.push_dropped = push_dropped_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CB'(spq_pkg::DEPTH))
    else $error("fill count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push |=> count_r == $past(count_r) + CB'(1))
    else $error("accepted push did not grow the queue");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && push_dropped_r) |-> entry_count_r == CB'(spq_pkg::DEPTH))
    else $error("dropped push reported on a queue that is not full");

  a_top_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> top_valid_r == (entry_count_r != '0))
    else $error("top valid flag disagrees with entry count");

  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    cell_occ[1] |-> cell_entry[0].pri >= cell_entry[1].pri)
    else $error("head of chain out of order");

endmodule
